// ===== rtl/core/bidc_pkg.sv =====
// Shared types and constants of the batch id dedup and cache lookup core.
// Depends on nothing; every module of the core imports it.
package bidc_pkg;

	localparam int ID_W       = 32;
	localparam int GEN_W      = 32;
	localparam int ROWCNT_W   = 33;
	localparam int IDXB_W     = 4;
	localparam int UIDX_W     = 10;
	localparam int OSLOT_W    = 12;
	localparam int TAG_W      = 33;
	localparam int HASH_W     = 64;
	localparam int CFG_IDX_W  = 2;
	localparam int FOLD_SHIFT = 16;

	localparam logic [HASH_W-1:0]   GOLDEN_MUL    = 64'h9E37_79B9_7F4A_7C15;
	localparam logic [TAG_W-1:0]    TAG_EMPTY     = '1;
	localparam logic [ROWCNT_W-1:0] ROW_COUNT_RST = 33'h1_0000_0000;
	localparam logic [IDXB_W-1:0]   IDX_BITS_RST  = 4'd12;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROW_COUNT = 2'd0,
		REG_CACHE_EN  = 2'd1,
		REG_IDX_BITS  = 2'd2
	} cfg_reg_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_RANGE = 2'd1,
		STAT_FULL  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_HASH,
		ST_PROBE
	} state_t;

	typedef struct packed {
		logic [ID_W-1:0]   key;
		logic [GEN_W-1:0]  gen;
		logic [UIDX_W-1:0] idx;
	} dd_word_t;

	typedef struct packed {
		logic rd;
		logic fill;
		logic clear;
	} tag_cmd_t;

endpackage

// ===== rtl/core/batch_id_dedup_cache_lookup_core.sv =====
// Top level of the batch id dedup and cache lookup core: control, dedup table, config.
// Depends on bidc_pkg, bidc_hash and bidc_tag_store.
//
//   channel   ports                                        handshake
//   --------  -------------------------------------------  ------------------------------
//   command   mode, batch_start, row_id                    taken when start & !busy
//   result    status, unique_index, first_seen,            one word per command, valid for
//             cache_hit, cache_slot                        the one cycle done is high
//   config    cfg_we, cfg_index, cfg_wdata                 written when cfg_we is high
//
// A flagged command (out of range, batch full, fill with the cache off) answers the
// cycle after it is taken and keeps busy low, except an out of range lookup that wraps
// the generation, which answers after the sweep. A fill waits on the two multiply stages
// of the hash; a lookup then probes the dedup table, one probe a cycle on its read port.
// A non power of two DEDUP_DEPTH adds a serial bucket reduction to both. After reset busy
// stays high while both memories are swept clear; a generation wrap sweeps the dedup
// table again. Config writes are taken in any cycle. The receiver cannot stall: each
// result word is shown once.
module batch_id_dedup_cache_lookup_core
	import bidc_pkg::*;
#(
	parameter int BATCH_CAPACITY = 1024,
	parameter int DEDUP_DEPTH    = 2048,
	parameter int CACHE_DEPTH    = 4096
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic                 mode,
	input  logic                 batch_start,
	input  logic [ID_W-1:0]      row_id,
	output logic                 done,
	output logic [1:0]           status,
	output logic [UIDX_W-1:0]    unique_index,
	output logic                 first_seen,
	output logic                 cache_hit,
	output logic [OSLOT_W-1:0]   cache_slot,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [ROWCNT_W-1:0]  cfg_wdata
);

	localparam int DA_W      = $clog2(DEDUP_DEPTH);
	localparam int CA_W      = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;
	localparam int MAXB      = $clog2(CACHE_DEPTH + 1) - 1;
	localparam int SLOT_W    = (MAXB > 0) ? MAXB : 1;
	localparam int CNT_W     = $clog2(BATCH_CAPACITY + 1);
	localparam int PC_W      = $clog2(DEDUP_DEPTH + 1);
	localparam int CLR_DEPTH = (DEDUP_DEPTH > CACHE_DEPTH) ? DEDUP_DEPTH : CACHE_DEPTH;
	localparam int CLR_W     = (CLR_DEPTH > 1) ? $clog2(CLR_DEPTH) : 1;

	// configuration registers
	logic [ROWCNT_W-1:0] row_count_q;
	logic                cache_en_q;
	logic [IDXB_W-1:0]   idx_bits_q;

	// control state
	state_t              state_q, state_d;
	logic [GEN_W-1:0]    gen_q, gen_d;
	logic [CNT_W-1:0]    item_q, item_d;
	logic [CNT_W-1:0]    dist_q, dist_d;
	logic [DA_W-1:0]     k_q, k_d;
	logic [PC_W-1:0]     prb_q, prb_d;
	logic [CLR_W-1:0]    clr_q, clr_d;
	logic                clr_tags_q, clr_tags_d;
	logic                wrap_q, wrap_d;
	logic                pend_oor_q, pend_oor_d;
	logic                h_rdy_q, h_rdy_d;

	// command word held for the whole lookup
	logic                mode_q;
	logic [ID_W-1:0]     id_q;

	// result word
	logic                done_q, done_d;
	status_t             status_q, status_d;
	logic [UIDX_W-1:0]   uidx_q, uidx_d;
	logic                first_q, first_d;
	logic                hit_q, hit_d;
	logic [OSLOT_W-1:0]  slot_q, slot_d;

	// dedup table
	dd_word_t            dd_mem [DEDUP_DEPTH];
	dd_word_t            dd_rdata_q;
	logic                dd_we, dd_re;
	logic [DA_W-1:0]     dd_waddr, dd_raddr;
	dd_word_t            dd_wdata;

	// hash unit and tag store
	logic                hash_go;
	logic                hash_done;
	logic [DA_W-1:0]     hash_bucket;
	logic [SLOT_W-1:0]   hash_slot;
	logic [SLOT_W-1:0]   slot_eff;
	tag_cmd_t            tag_cmd;
	logic [CA_W-1:0]     tag_addr;
	logic                tag_hit;

	// decode of the command being offered
	logic                accept;
	logic                new_batch;
	logic                wrap_now;
	logic [CNT_W-1:0]    item_eff;
	logic                batch_full;
	logic                id_oor;
	logic                clr_last;
	logic [DA_W-1:0]     k_next;

	bidc_hash #(
		.DEDUP_DEPTH (DEDUP_DEPTH),
		.CACHE_DEPTH (CACHE_DEPTH)
	) u_hash (
		.clk        (clk),
		.arst_n     (arst_n),
		.go         (hash_go),
		.row_id     (row_id),
		.index_bits (idx_bits_q),
		.done       (hash_done),
		.bucket     (hash_bucket),
		.slot       (hash_slot)
	);

	bidc_tag_store #(
		.CACHE_DEPTH (CACHE_DEPTH)
	) u_tags (
		.clk      (clk),
		.cmd      (tag_cmd),
		.addr     (tag_addr),
		.row_id   (id_q),
		.cache_en (cache_en_q),
		.hit      (tag_hit)
	);

	// config writes; an unknown index is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q <= ROW_COUNT_RST;
			cache_en_q  <= 1'b0;
			idx_bits_q  <= IDX_BITS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ROW_COUNT: row_count_q <= cfg_wdata;
				REG_CACHE_EN:  cache_en_q  <= cfg_wdata[0];
				REG_IDX_BITS:  idx_bits_q  <= cfg_wdata[IDXB_W-1:0];
				default: ;
			endcase
		end
	end

	assign accept     = start && (state_q == ST_IDLE);
	assign busy       = (state_q != ST_IDLE);
	// a lookup with no batch begun yet opens one
	assign new_batch  = batch_start || (gen_q == '0);
	assign wrap_now   = new_batch && (gen_q == '1);
	assign item_eff   = new_batch ? '0 : item_q;
	assign batch_full = (item_eff >= CNT_W'(BATCH_CAPACITY));
	assign id_oor     = ({1'b0, row_id} >= row_count_q);
	assign slot_eff   = cache_en_q ? hash_slot : '0;
	assign clr_last   = clr_tags_q ? (clr_q == CLR_W'(CLR_DEPTH - 1)) :
		(clr_q == CLR_W'(DEDUP_DEPTH - 1));
	assign k_next     = (k_q == DA_W'(DEDUP_DEPTH - 1)) ? '0 : k_q + 1'b1;

	always_comb begin
		state_d    = state_q;
		gen_d      = gen_q;
		item_d     = item_q;
		dist_d     = dist_q;
		k_d        = k_q;
		prb_d      = prb_q;
		clr_d      = clr_q;
		clr_tags_d = clr_tags_q;
		wrap_d     = wrap_q;
		pend_oor_d = pend_oor_q;
		h_rdy_d    = h_rdy_q || hash_done;
		done_d     = 1'b0;
		status_d   = STAT_OK;
		uidx_d     = '0;
		first_d    = 1'b0;
		hit_d      = 1'b0;
		slot_d     = '0;
		dd_we      = 1'b0;
		dd_waddr   = k_q;
		dd_wdata   = '0;
		dd_re      = 1'b0;
		dd_raddr   = k_next;
		tag_cmd    = '0;
		tag_addr   = CA_W'(hash_slot);
		hash_go    = 1'b0;

		case (state_q)
			ST_CLEAR: begin
				// sweep one entry a cycle; tags only after reset
				if ({1'b0, clr_q} < (CLR_W+1)'(DEDUP_DEPTH)) begin
					dd_we    = 1'b1;
					dd_waddr = clr_q[DA_W-1:0];
				end
				if (clr_tags_q && ({1'b0, clr_q} < (CLR_W+1)'(CACHE_DEPTH))) begin
					tag_cmd.clear = 1'b1;
					tag_addr      = clr_q[CA_W-1:0];
				end
				if (clr_last) begin
					clr_d = '0;
					if (!wrap_q) begin
						state_d = ST_IDLE;
					end else if (pend_oor_q) begin
						done_d   = 1'b1;
						status_d = STAT_RANGE;
						state_d  = ST_IDLE;
					end else begin
						state_d = ST_HASH;
					end
				end else begin
					clr_d = clr_q + 1'b1;
				end
			end

			ST_IDLE: begin
				if (start) begin
					h_rdy_d = 1'b0;
					if (mode) begin
						// fill: batch_start plays no part
						if (id_oor) begin
							done_d   = 1'b1;
							status_d = STAT_RANGE;
						end else if (!cache_en_q) begin
							done_d = 1'b1;
						end else begin
							hash_go = 1'b1;
							state_d = ST_HASH;
						end
					end else if (batch_full) begin
						done_d   = 1'b1;
						status_d = STAT_FULL;
					end else begin
						item_d = item_eff + 1'b1;
						if (new_batch) begin
							dist_d = '0;
							gen_d  = wrap_now ? GEN_W'(1) : gen_q + 1'b1;
						end
						hash_go = !id_oor;
						if (wrap_now) begin
							// stale generations must go before the lookup proceeds
							clr_d      = '0;
							clr_tags_d = 1'b0;
							wrap_d     = 1'b1;
							pend_oor_d = id_oor;
							state_d    = ST_CLEAR;
						end else if (id_oor) begin
							done_d   = 1'b1;
							status_d = STAT_RANGE;
						end else begin
							state_d = ST_HASH;
						end
					end
				end
			end

			ST_HASH: begin
				if (h_rdy_q || hash_done) begin
					if (mode_q) begin
						tag_cmd.fill = 1'b1;
						done_d       = 1'b1;
						slot_d       = OSLOT_W'(slot_eff);
						state_d      = ST_IDLE;
					end else begin
						// first probe and the tag read go out together
						dd_re      = 1'b1;
						dd_raddr   = hash_bucket;
						tag_cmd.rd = 1'b1;
						k_d        = hash_bucket;
						prb_d      = '0;
						state_d    = ST_PROBE;
					end
				end
			end

			ST_PROBE: begin
				if (dd_rdata_q.gen != gen_q) begin
					// free entry: claim it for this id
					dd_we        = 1'b1;
					dd_wdata.key = id_q;
					dd_wdata.gen = gen_q;
					dd_wdata.idx = UIDX_W'(dist_q);
					dist_d       = dist_q + 1'b1;
					done_d       = 1'b1;
					uidx_d       = UIDX_W'(dist_q);
					first_d      = 1'b1;
					hit_d        = tag_hit;
					slot_d       = OSLOT_W'(slot_eff);
					state_d      = ST_IDLE;
				end else if (dd_rdata_q.key == id_q) begin
					done_d  = 1'b1;
					uidx_d  = dd_rdata_q.idx;
					slot_d  = OSLOT_W'(slot_eff);
					state_d = ST_IDLE;
				end else if (prb_q == PC_W'(DEDUP_DEPTH - 1)) begin
					// every entry holds another id of this batch
					done_d   = 1'b1;
					status_d = STAT_FULL;
					state_d  = ST_IDLE;
				end else begin
					dd_re   = 1'b1;
					k_d     = k_next;
					prb_d   = prb_q + 1'b1;
				end
			end

			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			gen_q      <= '0;
			item_q     <= '0;
			dist_q     <= '0;
			k_q        <= '0;
			prb_q      <= '0;
			clr_q      <= '0;
			clr_tags_q <= 1'b1;
			wrap_q     <= 1'b0;
			pend_oor_q <= 1'b0;
			h_rdy_q    <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			state_q    <= state_d;
			gen_q      <= gen_d;
			item_q     <= item_d;
			dist_q     <= dist_d;
			k_q        <= k_d;
			prb_q      <= prb_d;
			clr_q      <= clr_d;
			clr_tags_q <= clr_tags_d;
			wrap_q     <= wrap_d;
			pend_oor_q <= pend_oor_d;
			h_rdy_q    <= h_rdy_d;
			done_q     <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= mode;
			id_q   <= row_id;
		end
		if (done_d) begin
			status_q <= status_d;
			uidx_q   <= uidx_d;
			first_q  <= first_d;
			hit_q    <= hit_d;
			slot_q   <= slot_d;
		end
	end

	// dedup table: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (dd_we) begin
			dd_mem[dd_waddr] <= dd_wdata;
		end
		if (dd_re) begin
			dd_rdata_q <= dd_mem[dd_raddr];
		end
	end

	assign done         = done_q;
	assign status       = status_q;
	assign unique_index = uidx_q;
	assign first_seen   = first_q;
	assign cache_hit    = hit_q;
	assign cache_slot   = slot_q;

endmodule

// ===== rtl/core/bidc_hash.sv =====
// Fibonacci hash of a row id: fold, two-stage multiply, slot mask and probe bucket.
// Depends on bidc_pkg; a non power of two table depth reduces the hash one bit a cycle.
module bidc_hash
	import bidc_pkg::*;
#(
	parameter int DEDUP_DEPTH = 2048,
	parameter int CACHE_DEPTH = 4096,
	localparam int DA_W   = $clog2(DEDUP_DEPTH),
	localparam int MAXB   = $clog2(CACHE_DEPTH + 1) - 1,
	localparam int SLOT_W = (MAXB > 0) ? MAXB : 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              go,
	input  logic [ID_W-1:0]   row_id,
	input  logic [IDXB_W-1:0] index_bits,
	output logic              done,
	output logic [DA_W-1:0]   bucket,
	output logic [SLOT_W-1:0] slot
);

	localparam bit D_POW2 = ((DEDUP_DEPTH & (DEDUP_DEPTH - 1)) == 0);

	logic [ID_W-1:0]     fold;
	logic [HASH_W-1:0]   prod_lo;
	logic [ID_W-1:0]     prod_hi;
	logic [HASH_W-1:0]   plo_s1;
	logic [ID_W-1:0]     phi_s1;
	logic [HASH_W-1:0]   h_s2;
	logic                v_s1;
	logic                v_s2;
	logic [IDXB_W:0]     bits_eff;
	logic [SLOT_W-1:0]   mask;

	assign fold    = row_id ^ (row_id >> FOLD_SHIFT);
	assign prod_lo = {{(HASH_W-ID_W){1'b0}}, fold} *
		{{(HASH_W-ID_W){1'b0}}, GOLDEN_MUL[ID_W-1:0]};
	assign prod_hi = fold * GOLDEN_MUL[HASH_W-1:ID_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= go;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			plo_s1 <= prod_lo;
			phi_s1 <= prod_hi;
		end
		if (v_s1) begin
			h_s2 <= plo_s1 + {phi_s1, {ID_W{1'b0}}};
		end
	end

	// saturate the slot bits at what the tag store can hold
	always_comb begin
		bits_eff = ({1'b0, index_bits} > (IDXB_W+1)'(MAXB)) ?
			(IDXB_W+1)'(MAXB) : {1'b0, index_bits};
		for (int i = 0; i < SLOT_W; i++) begin
			mask[i] = ((IDXB_W+1)'(i) < bits_eff);
		end
	end

	assign slot = h_s2[SLOT_W-1:0] & mask;

	generate
		if (D_POW2) begin : g_pow2
			assign done   = v_s2;
			assign bucket = h_s2[DA_W-1:0];
		end else begin : g_serial
			logic [DA_W-1:0]           rem_q;
			logic [HASH_W-1:0]         sh_q;
			logic [$clog2(HASH_W)-1:0] cnt_q;
			logic                      run_q;
			logic                      fin_q;
			logic [DA_W:0]             trial;
			logic [DA_W:0]             rem_nx;

			// restoring remainder, one hash bit per cycle from the top
			always_comb begin
				trial  = {rem_q, sh_q[HASH_W-1]};
				rem_nx = (trial >= (DA_W+1)'(DEDUP_DEPTH)) ?
					trial - (DA_W+1)'(DEDUP_DEPTH) : trial;
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					run_q <= 1'b0;
					fin_q <= 1'b0;
					cnt_q <= '0;
				end else begin
					fin_q <= run_q && (cnt_q == '1);
					if (v_s2) begin
						run_q <= 1'b1;
						cnt_q <= '0;
					end else if (run_q) begin
						cnt_q <= cnt_q + 1'b1;
						if (cnt_q == '1) begin
							run_q <= 1'b0;
						end
					end
				end
			end

			always_ff @(posedge clk) begin
				if (v_s2) begin
					rem_q <= '0;
					sh_q  <= h_s2;
				end else if (run_q) begin
					rem_q <= rem_nx[DA_W-1:0];
					sh_q  <= sh_q << 1;
				end
			end

			assign done   = fin_q;
			assign bucket = rem_q;
		end
	endgenerate

endmodule

// ===== rtl/core/bidc_tag_store.sv =====
// Direct-mapped cache tag store: one-port synchronous memory with tag compare.
// Depends on bidc_pkg for the tag word and the command struct.
module bidc_tag_store
	import bidc_pkg::*;
#(
	parameter int CACHE_DEPTH = 4096,
	localparam int CA_W = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1
) (
	input  logic            clk,
	input  tag_cmd_t        cmd,
	input  logic [CA_W-1:0] addr,
	input  logic [ID_W-1:0] row_id,
	input  logic            cache_en,
	output logic            hit
);

	logic [TAG_W-1:0] tags [CACHE_DEPTH];
	logic [TAG_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (cmd.clear) begin
			tags[addr] <= TAG_EMPTY;
		end else if (cmd.fill) begin
			tags[addr] <= {{(TAG_W-ID_W){1'b0}}, row_id};
		end
		if (cmd.rd) begin
			rdata_q <= tags[addr];
		end
	end

	// an empty tag has its top bit set and never matches an id
	assign hit = cache_en && (rdata_q == {{(TAG_W-ID_W){1'b0}}, row_id});

endmodule

// ===== tb/sv/tb_batch_id_dedup_cache_lookup_core.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for batch_id_dedup_cache_lookup_core: directed and random command
// words go through an in-bench dedup and tag-store predictor. Depends on bidc_pkg and the core.
module tb_batch_id_dedup_cache_lookup_core;
	import bidc_pkg::*;

	localparam int BATCH_CAPACITY = 1024;
	localparam int DEDUP_DEPTH    = 2048;
	localparam int CACHE_DEPTH    = 4096;
	localparam int DD_AW          = $clog2(DEDUP_DEPTH);
	// floor(log2(CACHE_DEPTH)): widest slot mask the core can use
	localparam int SLOT_BITS_MAX  = $clog2(CACHE_DEPTH + 1) - 1;
	// idle cycles with no word taken and no result shown before the run is called hung;
	// covers the post-reset sweep and the longest probe chain many times over
	localparam int STALL_LIMIT    = 20000;

	// one result word as the core presents it
	typedef struct packed {
		status_t             st;
		logic [UIDX_W-1:0]   uidx;
		logic                first;
		logic                hit;
		logic [OSLOT_W-1:0]  slot;
	} lookup_word_t;

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	logic                 mode;
	logic                 batch_start;
	logic [ID_W-1:0]      row_id;
	logic                 done;
	logic [1:0]           status;
	logic [UIDX_W-1:0]    unique_index;
	logic                 first_seen;
	logic                 cache_hit;
	logic [OSLOT_W-1:0]   cache_slot;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [ROWCNT_W-1:0]  cfg_wdata;

	// predictor copy of the core's registers and tables
	logic [ROWCNT_W-1:0]  row_limit = ROW_COUNT_RST;
	logic                 cache_on  = 1'b0;
	logic [IDXB_W-1:0]    idx_bits  = IDX_BITS_RST;
	logic [ID_W-1:0]      key_mem [DEDUP_DEPTH] = '{default: '0};
	logic [GEN_W-1:0]     gen_mem [DEDUP_DEPTH] = '{default: '0};
	logic [UIDX_W-1:0]    idx_mem [DEDUP_DEPTH] = '{default: '0};
	logic [TAG_W-1:0]     tag_mem [CACHE_DEPTH] = '{default: TAG_EMPTY};
	logic [GEN_W-1:0]     cur_gen      = '0;
	logic [10:0]          distinct_cnt = '0;
	logic [10:0]          batch_items  = '0;

	lookup_word_t pending_results [$];
	int           mismatch_count = 0;
	int           stall_cycles   = 0;
	int           gap_style      = 0;

	batch_id_dedup_cache_lookup_core #(
		.BATCH_CAPACITY(BATCH_CAPACITY),
		.DEDUP_DEPTH   (DEDUP_DEPTH),
		.CACHE_DEPTH   (CACHE_DEPTH)
	) i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.mode        (mode),
		.batch_start (batch_start),
		.row_id      (row_id),
		.done        (done),
		.status      (status),
		.unique_index(unique_index),
		.first_seen  (first_seen),
		.cache_hit   (cache_hit),
		.cache_slot  (cache_slot),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Predict the result word of one command and advance the predictor tables.
	// Lookup: fold and multiply the id, probe the dedup table linearly until an entry of
	// another generation or the same key turns up; a first occurrence takes the next dense
	// index and checks the tag store. Fill: with the cache on, write an in-range id's tag at its slot.
	function automatic lookup_word_t predict_lookup(input logic m, input logic bs,
			input logic [ID_W-1:0] id);
		logic [HASH_W-1:0]  fold;
		logic [HASH_W-1:0]  h;
		logic [12:0]        slot_mask;
		logic [OSLOT_W-1:0] slot;
		logic [DD_AW-1:0]   k;
		logic               found;
		int                 used_bits;
		lookup_word_t       r;

		fold = {32'd0, id} ^ ({32'd0, id} >> FOLD_SHIFT);
		h = fold * GOLDEN_MUL;
		// index bits above what the tag store holds saturate
		used_bits = (idx_bits > SLOT_BITS_MAX) ? SLOT_BITS_MAX : idx_bits;
		slot_mask = (13'd1 << used_bits) - 13'd1;
		slot = cache_on ? (h[OSLOT_W-1:0] & slot_mask[OSLOT_W-1:0]) : '0;
		r = '0;
		r.st = STAT_OK;

		if (m) begin
			// fill: batch_start is ignored, and with the cache off nothing is installed
			if ({1'b0, id} >= row_limit)
				r.st = STAT_RANGE;
			else if (cache_on) begin
				tag_mem[slot] = {1'b0, id};
				r.slot = slot;
			end
			return r;
		end

		// a lookup before any batch was begun opens one too
		if (bs || cur_gen == '0) begin
			cur_gen = cur_gen + 1;
			if (cur_gen == '0) begin
				// generation wrapped: drop every stored generation
				foreach (gen_mem[i])
					gen_mem[i] = '0;
				cur_gen = 1;
			end
			distinct_cnt = '0;
			batch_items = '0;
		end

		if (batch_items >= BATCH_CAPACITY) begin
			r.st = STAT_FULL;
			return r;
		end
		batch_items = batch_items + 1;
		// out of range ids count toward the batch but touch no table
		if ({1'b0, id} >= row_limit) begin
			r.st = STAT_RANGE;
			return r;
		end

		k = DD_AW'(h % DEDUP_DEPTH);
		found = 1'b0;
		for (int probes = 0; probes < DEDUP_DEPTH && !found; probes++) begin
			if (gen_mem[k] != cur_gen || key_mem[k] == id)
				found = 1'b1;
			else
				k = k + 1'b1;
		end

		if (!found) begin
			r.st = STAT_FULL;
		end else if (gen_mem[k] == cur_gen) begin
			// repeat occurrence: reuse the index, never a hit
			r.uidx = idx_mem[k];
			r.slot = slot;
		end else begin
			key_mem[k] = id;
			gen_mem[k] = cur_gen;
			idx_mem[k] = distinct_cnt[UIDX_W-1:0];
			r.uidx = distinct_cnt[UIDX_W-1:0];
			distinct_cnt = distinct_cnt + 1;
			r.first = 1'b1;
			r.hit = cache_on && (tag_mem[slot] == {1'b0, id});
			r.slot = slot;
		end
		return r;
	endfunction

	task automatic flag_mismatch(input string why, input lookup_word_t want,
			input lookup_word_t got);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%0t %s: expected st %0d idx %0d first %0b hit %0b slot %0d, got st %0d idx %0d first %0b hit %0b slot %0d",
				$realtime, why, want.st, want.uidx, want.first, want.hit, want.slot,
				got.st, got.uidx, got.first, got.hit, got.slot);
	endtask

	// Result checker. Every edge: check a shown result against the oldest expectation first,
	// then predict a word taken at this edge, then apply a register write. Keeping the three
	// in one process fixes their order inside the time step.
	always @(posedge clk) begin : result_check
		lookup_word_t got;
		lookup_word_t want;

		if (arst_n && done) begin
			got.st    = status_t'(status);
			got.uidx  = unique_index;
			got.first = first_seen;
			got.hit   = cache_hit;
			got.slot  = cache_slot;
			if (pending_results.size() == 0) begin
				flag_mismatch("result with no word outstanding", '0, got);
			end else begin
				want = pending_results.pop_front();
				if (got !== want)
					flag_mismatch("result mismatch", want, got);
			end
		end
		if (arst_n && start && !busy)
			pending_results.push_back(predict_lookup(mode, batch_start, row_id));
		if (arst_n && cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_ROW_COUNT: row_limit = cfg_wdata;
				REG_CACHE_EN:  cache_on  = cfg_wdata[0];
				REG_IDX_BITS:  idx_bits  = cfg_wdata[IDXB_W-1:0];
				default: ;
			endcase
		end
	end

	// Watchdog: count cycles with no word taken and no result shown.
	always @(posedge clk) begin
		if ((start && !busy) || done)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// Sender idle cycles ahead of the next word, by the current style:
	// 0 back to back, 1 a uniform random gap, 2 mostly back to back with an occasional random gap.
	function automatic int draw_gap();
		case (gap_style)
			1:       return $urandom_range(0, 18);
			2:       return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 18) : 0;
			default: return 0;
		endcase
	endfunction

	// Send one command word: hold start low for the drawn gap, then present the word
	// and hold it until the core takes it. start stays high afterwards so the next call
	// can go back to back.
	task automatic send_word(input logic m, input logic bs, input logic [ID_W-1:0] id);
		int gap;

		gap = draw_gap();
		@(negedge clk);
		if (gap > 0) begin
			start = 1'b0;
			repeat (gap) @(negedge clk);
		end
		mode        = m;
		batch_start = bs;
		row_id      = id;
		start       = 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	// Drop start, wait for every outstanding result, then let the core go idle before
	// registers are touched.
	task automatic settle();
		@(negedge clk);
		start = 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t r, input logic [ROWCNT_W-1:0] v);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_index = r;
		cfg_wdata = v;
		@(negedge clk);
		cfg_we    = 1'b0;
	endtask

	// Reset defaults: no batch begun yet, cache off, full id range.
	task automatic test_reset_defaults();
		settle();
		gap_style = 1;
		send_word(1'b0, 1'b0, 32'h0000_0000);  // opens the first batch by itself
		send_word(1'b0, 1'b0, 32'hFFFF_FFFF);
		send_word(1'b0, 1'b0, 32'h0000_0000);  // repeat keeps index 0
		send_word(1'b1, 1'b1, 32'hFFFF_FFFF);  // fill with the cache off does nothing
		send_word(1'b0, 1'b1, 32'h0000_0000);  // new batch restarts the dense index
	endtask

	// Fills followed by lookups: hits, misses, repeats, slot collisions, saturated index bits.
	task automatic test_cache_hits();
		settle();
		write_reg(REG_CACHE_EN, 1);
		write_reg(REG_IDX_BITS, 12);
		gap_style = 2;
		send_word(1'b1, 1'b0, 32'h1234_5678);
		send_word(1'b1, 1'b1, 32'hFFFF_FFFF);
		send_word(1'b1, 1'b0, 32'h0000_0000);
		send_word(1'b0, 1'b1, 32'h1234_5678);
		send_word(1'b0, 1'b0, 32'hFFFF_FFFF);
		send_word(1'b0, 1'b0, 32'h1234_5678);  // repeat occurrence never reports a hit
		send_word(1'b0, 1'b0, 32'hDEAD_BEEF);
		send_word(1'b0, 1'b0, 32'h0000_0000);
		// one slot in use: the second fill evicts the first
		settle();
		write_reg(REG_IDX_BITS, 0);
		send_word(1'b1, 1'b0, 32'h0000_0005);
		send_word(1'b1, 1'b0, 32'h0000_0009);
		send_word(1'b0, 1'b1, 32'h0000_0005);
		send_word(1'b0, 1'b0, 32'h0000_0009);
		// index bits above the store size saturate
		settle();
		write_reg(REG_IDX_BITS, 15);
		send_word(1'b1, 1'b0, 32'hA5A5_A5A5);
		send_word(1'b0, 1'b1, 32'hA5A5_A5A5);
		// cache off again: the tag is still there but every lookup misses
		settle();
		write_reg(REG_CACHE_EN, 0);
		send_word(1'b0, 1'b1, 32'hA5A5_A5A5);
	endtask

	// Row count limits: smallest count, and the top id at the edge of the range.
	task automatic test_row_limits();
		settle();
		write_reg(REG_ROW_COUNT, 1);
		write_reg(REG_CACHE_EN, 1);
		gap_style = 0;
		send_word(1'b0, 1'b1, 32'h0000_0000);
		send_word(1'b0, 1'b0, 32'h0000_0001);
		send_word(1'b0, 1'b0, 32'hFFFF_FFFF);
		send_word(1'b1, 1'b0, 32'h0000_0007);  // out of range fill installs nothing
		settle();
		write_reg(REG_ROW_COUNT, 33'h0_FFFF_FFFF);
		send_word(1'b0, 1'b1, 32'hFFFF_FFFF);
		send_word(1'b0, 1'b0, 32'hFFFF_FFFE);
		send_word(1'b1, 1'b0, 32'hFFFF_FFFF);
	endtask

	// Fill one batch to capacity with distinct ids (drives every unique_index bit),
	// then overflow it; fills still work, and a new batch opens again.
	task automatic test_batch_capacity();
		logic [ID_W-1:0] base;

		settle();
		write_reg(REG_ROW_COUNT, ROW_COUNT_RST);
		write_reg(REG_CACHE_EN, 1);
		write_reg(REG_IDX_BITS, 6);
		base = $urandom();
		gap_style = 2;
		for (int i = 0; i < BATCH_CAPACITY; i++)
			send_word(1'b0, i == 0, base ^ i);
		send_word(1'b0, 1'b0, base);            // repeat past capacity
		send_word(1'b0, 1'b0, ~base);           // new id past capacity
		send_word(1'b1, 1'b0, base ^ 32'd3);
		send_word(1'b0, 1'b0, base ^ 32'd3);
		send_word(1'b0, 1'b1, base ^ 32'd3);
	endtask

	// Random phases: each picks register values, an idle style and a small id pool so
	// that repeats, fills then hits, and slot collisions are common; a few ids are
	// fully random noise.
	task automatic test_random_traffic();
		logic [ID_W-1:0]     pool [64];
		logic [ROWCNT_W-1:0] rc;
		logic                m;
		logic                bs;
		logic [ID_W-1:0]     id;
		int                  pool_n;
		int                  rc_kind;

		for (int ph = 0; ph < 11; ph++) begin
			settle();
			rc_kind = $urandom_range(0, 2);
			case (rc_kind)
				0:       rc = ROW_COUNT_RST;
				1:       rc = $urandom_range(1, 3000);
				default: rc = {1'b0, $urandom()};
			endcase
			if (rc == '0)
				rc = 1;
			write_reg(REG_ROW_COUNT, rc);
			write_reg(REG_CACHE_EN, (ph == 0) ? 1 : $urandom_range(0, 1));
			write_reg(REG_IDX_BITS, $urandom_range(0, 15));
			// first phase runs with no idling at all
			gap_style = (ph == 0) ? 0 : $urandom_range(0, 2);
			pool_n = $urandom_range(4, 64);
			for (int i = 0; i < pool_n; i++)
				pool[i] = (rc_kind == 1) ? $urandom_range(0, 3500) : $urandom();
			for (int n = 0; n < 155; n++) begin
				m  = ($urandom_range(0, 3) == 0);
				// batch_start is a don't-care on fills, so toggle it freely there
				bs = m ? $urandom_range(0, 1) : ($urandom_range(0, 11) == 0);
				id = ($urandom_range(0, 12) == 0) ? $urandom() :
					pool[$urandom_range(0, pool_n - 1)];
				send_word(m, bs, id);
			end
		end
	endtask

	initial begin
		arst_n      = 1'b0;
		start       = 1'b0;
		mode        = 1'b0;
		batch_start = 1'b0;
		row_id      = '0;
		cfg_we      = 1'b0;
		cfg_index   = REG_ROW_COUNT;
		cfg_wdata   = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_defaults();
		test_cache_hits();
		test_row_limits();
		test_batch_capacity();
		test_random_traffic();

		settle();
		repeat (20) @(posedge clk);
		if (mismatch_count == 0 && pending_results.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/bidc_pkg.sv
rtl/core/bidc_hash.sv
rtl/core/bidc_tag_store.sv
rtl/core/batch_id_dedup_cache_lookup_core.sv
tb/sv/tb_batch_id_dedup_cache_lookup_core.sv
